@@ rtl/core/tla_pkg.sv @@
// Package with shared constants, table and helper functions for the thermistor linearizer.
package tla_pkg;

    localparam int AVG_DEPTH_DEF    = 8;
    localparam int ADC_BITS_DEF     = 12;
    localparam int TABLE_POINTS_DEF = 16;
    localparam int TBL_STORED       = 16;
    localparam int SERIES_W         = 16;
    localparam int RES_W            = 28;
    localparam int TEMP_W           = 11;
    localparam int ADC_W            = 12;
    localparam logic [SERIES_W-1:0] SERIES_RESET = 16'd150;
    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
    localparam int TEMP_MIN = -1024;
    localparam int TEMP_MAX = 1023;
    localparam int DEN_W = 20;
    localparam int QUO_W = 26;

    function automatic logic [11:0] tbl_ohms(input logic [3:0] idx);
        logic [11:0] v;
        unique case (idx)
            4'd0:  v = 12'd3200;
            4'd1:  v = 12'd2150;
            4'd2:  v = 12'd1420;
            4'd3:  v = 12'd895;
            4'd4:  v = 12'd620;
            4'd5:  v = 12'd428;
            4'd6:  v = 12'd304;
            4'd7:  v = 12'd224;
            4'd8:  v = 12'd160;
            4'd9:  v = 12'd124;
            4'd10: v = 12'd95;
            4'd11: v = 12'd73;
            4'd12: v = 12'd59;
            4'd13: v = 12'd45;
            4'd14: v = 12'd37;
            default: v = 12'd30;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] tbl_degf(input logic [3:0] idx);
        return 9'(68 + 18 * int'(idx));
    endfunction

endpackage

@@ rtl/core/tla_stream_if.sv @@
// Valid/ready stream interfaces for the input and result channels.
interface tla_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_code;
    modport source (output valid, output adc_code, input ready);
    modport sink (input valid, input adc_code, output ready);
endinterface

interface tla_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] temp_avg_f;
    logic [27:0] res_avg_q8;
    logic [10:0] temp_now_f;
    logic        clipped;
    modport source (output valid, output temp_avg_f, output res_avg_q8, output temp_now_f,
                    output clipped, input ready);
    modport sink (input valid, input temp_avg_f, input res_avg_q8, input temp_now_f,
                  input clipped, output ready);
endinterface

@@ rtl/core/tla_divider.sv @@
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module tla_divider
    import tla_pkg::*;
#(
    parameter int NUM_W = 44,
    parameter int DEN_BITS = 20
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                done,
    output logic [NUM_W-1:0]    quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]    q_reg;
    logic [DEN_BITS-1:0] r_reg;
    logic [DEN_BITS-1:0] d_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;

    assign trial = {r_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                q_reg    <= numer;
                r_reg    <= '0;
                d_reg    <= denom;
            end
            else if (busy_reg)
            begin
                if (!diff[DEN_BITS])
                begin
                    r_reg <= diff[DEN_BITS-1:0];
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial[DEN_BITS-1:0];
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

@@ rtl/core/thermistor_linearize_average.sv @@
// Top level: divider-based thermistor linearizer with moving averages.
// Each result comes from four 48-step bit-serial divisions (resistance, interpolation,
// two averages) in one shared divider.
// No new sample is accepted until the last result is loaded; a result still held in the output
// register when the next one is ready stalls the block until it is taken.
// Reset: asynchronous active low; clears control state, series_reg to 150, rings unprimed.
module thermistor_linearize_average
    import tla_pkg::*;
#(
    parameter int AVG_DEPTH    = AVG_DEPTH_DEF,
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SERIES_W-1:0] cfg_wdata,
    tla_in_if.sink              in_ch,
    tla_out_if.source           out_ch
);
    localparam int ADC_BITS = ADC_BITS_DEF;
    localparam int NPTS   = (TABLE_POINTS < 2) ? 2 :
                            ((TABLE_POINTS > TBL_STORED) ? TBL_STORED : TABLE_POINTS);
    localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int LOG_D  = $clog2(AVG_DEPTH);
    localparam int TSUM_W = TEMP_W + LOG_D + 2;
    localparam int RSUM_W = RES_W + LOG_D + 1;
    localparam int NUM_W  = 48;
    localparam int DW     = 32;
    localparam logic [3:0] LAST_IDX = 4'(NPTS - 1);
    localparam logic [3:0] SEG_LAST = 4'(NPTS - 2);

    typedef enum logic [3:0] {
        S_IDLE, S_RES_START, S_RES_WAIT, S_SEG, S_MUL, S_TMP_START, S_TMP_WAIT, S_TEMP,
        S_RING, S_AVG_START, S_AVG_WAIT, S_OUT
    } state_t;

    state_t                   state_reg;
    logic [SERIES_W-1:0]      series_reg;
    logic [ADC_BITS-1:0]      code_reg;
    logic [RES_W-1:0]         res_reg;
    logic                     clip_reg;
    logic [3:0]               seg_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DW-1:0]            den_reg;
    logic                     neg_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     primed_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [TSUM_W-1:0] tsum_reg;
    logic [RSUM_W-1:0]        rsum_reg;
    logic [TEMP_W-1:0]        temp_ring [AVG_DEPTH];
    logic [RES_W-1:0]         res_ring [AVG_DEPTH];
    logic                     avg_phase_reg;
    logic [TEMP_W-1:0]        tavg_reg;
    logic [RES_W-1:0]         ravg_reg;
    logic                     out_valid_reg;
    logic [TEMP_W-1:0]        out_tavg_reg;
    logic [RES_W-1:0]         out_ravg_reg;

    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DW-1:0]            div_den;
    logic                     div_done;
    logic [NUM_W-1:0]         div_q;

    tla_divider #(.NUM_W(NUM_W), .DEN_BITS(DW)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .numer  (div_num),
        .denom  (div_den),
        .done   (div_done),
        .quot   (div_q)
    );

    logic [NUM_W-1:0] num_abs;
    logic [NUM_W-1:0] tsum_abs;
    logic [35:0]      r_hi_q8;
    logic [35:0]      r_lo_q8;
    logic signed [NUM_W-1:0] q_signed;
    logic [3:0]       seg_search;
    logic             out_load;

    assign num_abs  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign tsum_abs = tsum_reg[TSUM_W-1] ? NUM_W'(-tsum_reg) : NUM_W'(tsum_reg);
    assign r_hi_q8  = {16'd0, tbl_ohms(seg_reg), 8'd0};
    assign r_lo_q8  = {16'd0, tbl_ohms(seg_reg + 4'd1), 8'd0};
    assign q_signed = neg_reg ? -$signed(div_q) : $signed(div_q);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        seg_search = SEG_LAST;
        for (int i = NPTS - 2; i >= 0; i--)
        begin
            if ({8'd0, res_reg} > {tbl_ohms(4'(i + 1)), 8'd0})
            begin
                seg_search = 4'(i);
            end
        end
        if ({8'd0, res_reg} <= {tbl_ohms(LAST_IDX), 8'd0})
        begin
            seg_search = SEG_LAST;
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_RES_START:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({code_reg, 8'd0}) * NUM_W'(series_reg);
                div_den   = DW'((1 << ADC_BITS) - int'(code_reg));
            end
            S_TMP_START:
            begin
                div_start = 1'b1;
                div_num   = num_abs;
                div_den   = den_reg;
            end
            S_AVG_START:
            begin
                div_start = 1'b1;
                div_num   = avg_phase_reg ? NUM_W'(rsum_reg) : tsum_abs;
                div_den   = DW'(AVG_DEPTH);
            end
            default:
            begin
            end
        endcase
    end

    logic [NUM_W-1:0] q_keep;
    assign q_keep = div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            series_reg    <= SERIES_RESET;
            primed_reg    <= 1'b0;
            pos_reg       <= '0;
            tsum_reg      <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
            avg_phase_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                series_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        code_reg  <= in_ch.adc_code[ADC_BITS-1:0];
                        clip_reg  <= 1'b0;
                        state_reg <= S_RES_START;
                    end
                end
                S_RES_START: state_reg <= S_RES_WAIT;
                S_RES_WAIT:
                begin
                    if (div_done)
                    begin
                        if (q_keep > NUM_W'(RES_MAX))
                        begin
                            res_reg  <= RES_MAX;
                            clip_reg <= 1'b1;
                        end
                        else
                        begin
                            res_reg <= q_keep[RES_W-1:0];
                        end
                        state_reg <= S_SEG;
                    end
                end
                S_SEG:
                begin
                    seg_reg   <= seg_search;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    den_reg <= DW'(r_hi_q8 - r_lo_q8);
                    num_reg <= NUM_W'($signed({1'b0, tbl_degf(seg_reg)})) *
                               $signed(NUM_W'(r_hi_q8 - r_lo_q8)) +
                               NUM_W'($signed(10'(tbl_degf(seg_reg + 4'd1) -
                                                  tbl_degf(seg_reg)))) *
                               ($signed(NUM_W'(r_hi_q8)) - $signed(NUM_W'(res_reg)));
                    state_reg <= S_TMP_START;
                end
                S_TMP_START:
                begin
                    neg_reg   <= num_reg[NUM_W-1];
                    state_reg <= S_TMP_WAIT;
                end
                S_TMP_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_TEMP;
                    end
                end
                S_TEMP:
                begin
                    if (q_signed < NUM_W'(TEMP_MIN))
                    begin
                        temp_reg <= TEMP_W'(TEMP_MIN);
                        clip_reg <= 1'b1;
                    end
                    else if (q_signed > NUM_W'(TEMP_MAX))
                    begin
                        temp_reg <= TEMP_W'(TEMP_MAX);
                        clip_reg <= 1'b1;
                    end
                    else
                    begin
                        temp_reg <= TEMP_W'(q_signed);
                    end
                    state_reg <= S_RING;
                end
                S_RING:
                begin
                    if (!primed_reg)
                    begin
                        for (int i = 0; i < AVG_DEPTH; i++)
                        begin
                            temp_ring[i] <= temp_reg;
                            res_ring[i]  <= res_reg;
                        end
                        tsum_reg   <= TSUM_W'(temp_reg) * TSUM_W'(AVG_DEPTH);
                        rsum_reg   <= RSUM_W'(res_reg) * RSUM_W'(AVG_DEPTH);
                        pos_reg    <= '0;
                        primed_reg <= 1'b1;
                    end
                    else
                    begin
                        tsum_reg <= tsum_reg - TSUM_W'($signed(temp_ring[pos_reg]))
                                    + TSUM_W'(temp_reg);
                        rsum_reg <= rsum_reg - RSUM_W'(res_ring[pos_reg]) + RSUM_W'(res_reg);
                        temp_ring[pos_reg] <= temp_reg;
                        res_ring[pos_reg]  <= res_reg;
                        pos_reg <= (int'(pos_reg) == AVG_DEPTH - 1) ? '0 : pos_reg + 1'b1;
                    end
                    avg_phase_reg <= 1'b0;
                    state_reg     <= S_AVG_START;
                end
                S_AVG_START:
                begin
                    neg_reg   <= tsum_reg[TSUM_W-1] & ~avg_phase_reg;
                    state_reg <= S_AVG_WAIT;
                end
                S_AVG_WAIT:
                begin
                    if (div_done)
                    begin
                        if (avg_phase_reg)
                        begin
                            ravg_reg  <= q_keep[RES_W-1:0];
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            tavg_reg      <= q_signed[TEMP_W-1:0];
                            avg_phase_reg <= 1'b1;
                            state_reg     <= S_AVG_START;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [TEMP_W-1:0] out_tnow_reg;
    logic              out_clip_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_tavg_reg <= tavg_reg;
            out_ravg_reg <= ravg_reg;
            out_tnow_reg <= temp_reg;
            out_clip_reg <= clip_reg;
        end
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.temp_avg_f = out_tavg_reg;
    assign out_ch.res_avg_q8 = out_ravg_reg;
    assign out_ch.temp_now_f = out_tnow_reg;
    assign out_ch.clipped    = out_clip_reg;
endmodule

@@ rtl/core/tla_checker.sv @@
// Port-level checker for the thermistor linearizer, bound to the top level.
module tla_checker
    import tla_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [10:0] temp_now_f,
    input logic        clipped
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(temp_now_f) && $stable(clipped))
        else $error("Stalled result changed.");

    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input accepted while busy.");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("Result valid right after reset.");
endmodule

bind thermistor_linearize_average tla_checker u_tla_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .temp_now_f (out_ch.temp_now_f),
    .clipped    (out_ch.clipped)
);

@@ test/tb.sv @@
// Self-checking testbench for the thermistor linearizer with moving averages.
module tb;
    import tla_pkg::*;

    localparam int DEPTH = 8;
    localparam int LIMIT = 2_000_000;

    typedef struct packed {
        logic [10:0] temp_avg_f;
        logic [27:0] res_avg_q8;
        logic [10:0] temp_now_f;
        logic        clipped;
    } reading_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SERIES_W-1:0] cfg_wdata;
    int errors;
    int cycles;
    int sent;
    int checked;
    int clip_seen;
    int ready_wait;

    tla_in_if in_ch();
    tla_out_if out_ch();

    thermistor_linearize_average u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    logic [15:0] series_model;
    logic signed [10:0] temp_ring[DEPTH];
    logic [27:0] res_ring[DEPTH];
    logic signed [31:0] temp_total;
    logic [31:0] res_total;
    int ring_pos;
    bit primed;
    reading_t pending_readings[$];

    int ohms_pts[16] = '{3200, 2150, 1420, 895, 620, 428, 304, 224,
                         160, 124, 95, 73, 59, 45, 37, 30};

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint degf_at(input int seg);
        return 68 + 18 * seg;
    endfunction

    function automatic reading_t linearize(input logic [11:0] code);
        reading_t r;
        longint rq;
        longint t;
        longint r0;
        longint r1;
        longint den;
        int seg;
        bit clip;
        clip = 1'b0;
        rq = (longint'(code) * series_model * 256) / (4096 - longint'(code));
        if (rq > longint'(RES_MAX)) begin
            rq = RES_MAX;
            clip = 1'b1;
        end
        if (rq > longint'(ohms_pts[0]) * 256) seg = 0;
        else if (rq <= longint'(ohms_pts[15]) * 256) seg = 14;
        else begin
            seg = 0;
            for (int i = 0; i < 15; i++) begin
                if (rq <= longint'(ohms_pts[i]) * 256 && rq > longint'(ohms_pts[i+1]) * 256) begin
                    seg = i;
                    break;
                end
            end
        end
        r0 = longint'(ohms_pts[seg]) * 256;
        r1 = longint'(ohms_pts[seg+1]) * 256;
        den = r0 - r1;
        t = (degf_at(seg) * den + (degf_at(seg + 1) - degf_at(seg)) * (r0 - rq)) / den;
        if (t < TEMP_MIN) begin
            t = TEMP_MIN;
            clip = 1'b1;
        end
        if (t > TEMP_MAX) begin
            t = TEMP_MAX;
            clip = 1'b1;
        end
        if (!primed) begin
            for (int i = 0; i < DEPTH; i++) begin
                temp_ring[i] = 11'(t);
                res_ring[i] = 28'(rq);
            end
            temp_total = 32'(t) * DEPTH;
            res_total = 32'(rq) * DEPTH;
            ring_pos = 0;
            primed = 1'b1;
        end else begin
            temp_total = temp_total - temp_ring[ring_pos] + 32'(t);
            res_total = res_total - res_ring[ring_pos] + 32'(rq);
            temp_ring[ring_pos] = 11'(t);
            res_ring[ring_pos] = 28'(rq);
            ring_pos = (ring_pos + 1) % DEPTH;
        end
        r.temp_avg_f = 11'(temp_total / DEPTH);
        r.res_avg_q8 = 28'(res_total / DEPTH);
        r.temp_now_f = 11'(t);
        r.clipped = clip;
        return r;
    endfunction

    task automatic send_code(input logic [11:0] code);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.adc_code <= code;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_readings.push_back(linearize(code));
        if (pending_readings[$].clipped) clip_seen++;
        sent++;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_readings();
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_series(input logic [15:0] ohms);
        drain_readings();
        cfg_we <= 1'b1;
        cfg_wdata <= ohms;
        @(posedge clk);
        cfg_we <= 1'b0;
        series_model = ohms;
    endtask

    task automatic test_directed_codes();
        logic [11:0] codes[] = '{12'd2048, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'hAAA,
                                 12'h555, 12'd100, 12'd3000, 12'd2500, 12'd1000, 12'd3900};
        foreach (codes[i]) send_code(codes[i]);
    endtask

    task automatic test_series_extremes();
        write_series(16'd65535);
        for (int i = 0; i < 6; i++) send_code(12'($urandom_range(0, 4095)));
        send_code(12'd4095);
        write_series(16'd1);
        send_code(12'd4095);
        send_code(12'd0);
        send_code(12'd2048);
        write_series(16'd0);
        send_code(12'd3000);
        send_code(12'd4095);
    endtask

    task automatic test_random_codes(input int count);
        logic [15:0] settings[] = '{16'd150, 16'd1000, 16'd47, 16'd10000, 16'd65535, 16'd1};
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) write_series(settings[(i / 200) % settings.size()]);
            if (i == count / 2) drain_readings();
            case ($urandom_range(0, 3))
                0: send_code(12'($urandom()));
                1: send_code(12'($urandom_range(1500, 3800)));
                2: send_code($urandom_range(0, 1) ? 12'($urandom_range(0, 40))
                                                  : 12'($urandom_range(4050, 4095)));
                default: send_code(12'($urandom_range(0, 4095)));
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            cycles <= cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                reading_t want;
                reading_t got;
                got = '{out_ch.temp_avg_f, out_ch.res_avg_q8, out_ch.temp_now_f, out_ch.clipped};
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected transaction %h", $time, got);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    checked++;
                    if (got.temp_avg_f !== want.temp_avg_f)
                        $display("%0t: temp_avg_f expected %0d actual %0d", $time,
                                 $signed(want.temp_avg_f), $signed(got.temp_avg_f));
                    if (got.res_avg_q8 !== want.res_avg_q8)
                        $display("%0t: res_avg_q8 expected %0d actual %0d", $time,
                                 want.res_avg_q8, got.res_avg_q8);
                    if (got.temp_now_f !== want.temp_now_f)
                        $display("%0t: temp_now_f expected %0d actual %0d", $time,
                                 $signed(want.temp_now_f), $signed(got.temp_now_f));
                    if (got.clipped !== want.clipped)
                        $display("%0t: clipped expected %0b actual %0b", $time,
                                 want.clipped, got.clipped);
                    if (got !== want) errors++;
                end
                out_ch.ready <= 1'b0;
                ready_wait <= $urandom_range(0, 19);
            end
            else if (out_ch.valid)
            begin
                if (ready_wait == 0)
                    out_ch.ready <= 1'b1;
                else
                    ready_wait <= ready_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT) begin
            $display("** thermistor_linearize_average: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.adc_code = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        cycles = 0;
        sent = 0;
        checked = 0;
        clip_seen = 0;
        ready_wait = 0;
        series_model = SERIES_RESET;
        primed = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_codes();
        test_series_extremes();
        test_random_codes(1700);
        drain_readings();
        $display("Sent %0d samples across several series resistor values; %0d results checked.",
                 sent, checked);
        $display("Of these, %0d samples hit resistance or temperature saturation.", clip_seen);
        if (errors == 0)
            $display("** thermistor_linearize_average: PASSED **");
        else
            $display("** thermistor_linearize_average: FAILED **");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/tla_pkg.sv
rtl/core/tla_stream_if.sv
rtl/core/tla_divider.sv
rtl/core/thermistor_linearize_average.sv
rtl/core/tla_checker.sv
test/tb.sv
